### rtl/sorted_insert_queue_defines.svh
// Assertion macros used by the sorted insert queue port-level checker.
`ifndef SORTED_INSERT_QUEUE_DEFINES_SVH
`define SORTED_INSERT_QUEUE_DEFINES_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define SIQ_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("sorted_insert_queue check failed");

// Next-cycle implication, sampled on clock, off during reset.
`define SIQ_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("sorted_insert_queue check failed");

`endif

### rtl/siq_pkg.sv
// Types and constants of the sorted insert queue.
package siq_pkg;

   localparam int unsigned CAPACITY_DEFAULT = 128;
   localparam int unsigned KEY_WIDTH        = 32;

   typedef logic signed [KEY_WIDTH-1:0] key_type;

   typedef enum logic {
      CMD_INSERT = 1'b0,
      CMD_POP    = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK           = 2'd0,
      ST_EMPTY_POP    = 2'd1,
      ST_TAIL_EVICTED = 2'd2,
      ST_KEY_REJECTED = 2'd3
   } status_type;

   // Control broadcast to every cell of the row.
   typedef struct packed {
      logic    en;
      cmd_type cmd;
   } cell_ctrl_type;

endpackage

### rtl/siq_cell.sv
// One cell of the sorted row: holds one entry, compares and shifts.
module siq_cell (
   input  logic                  clock,
   input  siq_pkg::cell_ctrl_type ctrl,
   input  siq_pkg::key_type      key,
   input  logic                  occupied,
   input  logic                  gt_up,
   input  siq_pkg::key_type      val_up,
   input  siq_pkg::key_type      val_dn,
   output logic                  gt,
   output siq_pkg::key_type      val,
   output siq_pkg::key_type      val_next
);
   import siq_pkg::*;

   key_type val_ff;
   key_type val_in;

   // Held entry is strictly greater than the key: it stays in front.
   assign gt = occupied && (key < val_ff);

   always_comb begin
      val_in = val_ff;
      if (ctrl.cmd == CMD_POP) begin
         val_in = val_dn;
      end else if (gt) begin
         val_in = val_ff;
      end else if (gt_up) begin
         val_in = key;
      end else begin
         val_in = val_up;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.en) begin
         val_ff <= val_in;
      end
   end

   assign val      = val_ff;
   assign val_next = val_in;

endmodule

### rtl/sorted_insert_queue.sv
// Sorted insert queue: row of compare-and-shift cells, descending order.
// A result beat is registered and shown in the cycle after its request beat is taken.
// Throughput: one request per cycle while the result side is not stalled; every cell
//    compares the broadcast key with its entry and shifts in the same cycle, so the row sets the clock.
// Reset clears the entry count and the result valid; entries are not cleared,
//    only cells below the count are ever looked at.
module sorted_insert_queue #(
   parameter int unsigned CAPACITY = siq_pkg::CAPACITY_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_cmd,
   input  siq_pkg::key_type    req_key,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output siq_pkg::key_type    rsp_out_value,
   output logic [1:0]          rsp_status,
   output logic [7:0]          rsp_entry_count,
   output siq_pkg::key_type    rsp_head_value,
   output siq_pkg::key_type    rsp_tail_value,
   output logic                rsp_is_empty,
   output logic                rsp_is_full
);
   import siq_pkg::*;

   localparam int unsigned CountW = $clog2(CAPACITY + 1);
   localparam logic [CountW-1:0] CapCount = CountW'(CAPACITY);

   // Row wiring.
   key_type       val    [CAPACITY];
   key_type       val_nx [CAPACITY];
   logic          gt     [CAPACITY];
   cell_ctrl_type ctrl;

   // Queue state.
   logic [CountW-1:0] count_ff, count_in;
   key_type           tail_ff, tail_in;

   // Result register.
   logic       rsp_valid_ff;
   key_type    out_value_ff, out_value_in;
   status_type status_ff, status_in;
   logic [7:0] entry_count_ff;
   key_type    head_ff, head_in;
   key_type    tail_out_ff, tail_out_in;
   logic       empty_ff, full_ff;

   logic    accept;
   cmd_type cmd;
   logic    is_full_now;
   logic    is_empty_now;

   // Take a new beat whenever the result slot is free or drains this cycle.
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign cmd       = cmd_type'(req_cmd);

   assign ctrl.en  = accept;
   assign ctrl.cmd = cmd;

   assign is_full_now  = (count_ff == CapCount);
   assign is_empty_now = (count_ff == '0);

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic    occ;
      logic    gt_up_w;
      key_type up_w;
      key_type dn_w;

      assign occ = (CountW'(i) < count_ff);
      if (i == 0) begin : g_first
         // Nothing sits ahead of the head: the key lands here unless passed.
         assign gt_up_w = 1'b1;
         assign up_w    = req_key;
      end else begin : g_mid
         assign gt_up_w = gt[i-1];
         assign up_w    = val[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign dn_w = val[i];
      end else begin : g_inner
         assign dn_w = val[i+1];
      end

      siq_cell u_cell (
         .clock    (clock),
         .ctrl     (ctrl),
         .key      (req_key),
         .occupied (occ),
         .gt_up    (gt_up_w),
         .val_up   (up_w),
         .val_dn   (dn_w),
         .gt       (gt[i]),
         .val      (val[i]),
         .val_next (val_nx[i])
      );
   end

   // Decide status, dropped value, new count and new tail.
   always_comb begin
      count_in     = count_ff;
      tail_in      = tail_ff;
      out_value_in = '0;
      status_in    = ST_OK;
      if (cmd == CMD_POP) begin
         if (is_empty_now) begin
            status_in = ST_EMPTY_POP;
         end else begin
            out_value_in = val[0];
            count_in     = count_ff - CountW'(1);
         end
      end else if (!is_full_now) begin
         count_in = count_ff + CountW'(1);
         // Key becomes the tail when below the old tail or the queue is empty.
         if (is_empty_now || (req_key < tail_ff)) begin
            tail_in = req_key;
         end
      end else if (gt[CAPACITY-1]) begin
         // Below every entry: drop the key, leave the row alone.
         status_in    = ST_KEY_REJECTED;
         out_value_in = req_key;
      end else begin
         // Drop the old tail; the last cell shows the new one.
         status_in    = ST_TAIL_EVICTED;
         out_value_in = val[CAPACITY-1];
         tail_in      = val_nx[CAPACITY-1];
      end
   end

   assign head_in     = (count_in == '0) ? '0 : val_nx[0];
   assign tail_out_in = (count_in == '0) ? '0 : tail_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            count_ff     <= count_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload: advance on every accepted beat, hold otherwise.
   always_ff @(posedge clock) begin
      if (accept) begin
         tail_ff        <= tail_in;
         out_value_ff   <= out_value_in;
         status_ff      <= status_in;
         entry_count_ff <= 8'(count_in);
         head_ff        <= head_in;
         tail_out_ff    <= tail_out_in;
         empty_ff       <= (count_in == '0);
         full_ff        <= (count_in == CapCount);
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_value   = out_value_ff;
   assign rsp_status      = status_ff;
   assign rsp_entry_count = entry_count_ff;
   assign rsp_head_value  = head_ff;
   assign rsp_tail_value  = tail_out_ff;
   assign rsp_is_empty    = empty_ff;
   assign rsp_is_full     = full_ff;

endmodule

### rtl/siq_checker.sv
// Port-level checker for the sorted insert queue, bound to the top level.
`include "sorted_insert_queue_defines.svh"

module siq_checker (
   input logic                clock,
   input logic                reset,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input siq_pkg::key_type    rsp_out_value,
   input logic [1:0]          rsp_status,
   input logic [7:0]          rsp_entry_count,
   input siq_pkg::key_type    rsp_head_value,
   input siq_pkg::key_type    rsp_tail_value,
   input logic                rsp_is_empty,
   input logic                rsp_is_full
);
   import siq_pkg::*;

   // A stalled result beat holds its value.
   `SIQ_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_out_value))
   // An empty queue reports zero count, zero head and tail, and is not full.
   `SIQ_ASSERT_NOW(a_empty_shape, rsp_valid && rsp_is_empty, rsp_entry_count == 8'd0 && rsp_head_value == '0 && rsp_tail_value == '0 && !rsp_is_full)
   // A pop on empty leaves the queue empty and drops nothing.
   `SIQ_ASSERT_NOW(a_empty_pop, rsp_valid && rsp_status == ST_EMPTY_POP, rsp_is_empty && rsp_out_value == '0)
   // Eviction and rejection only happen on a full queue.
   `SIQ_ASSERT_NOW(a_drop_full, rsp_valid && (rsp_status == ST_TAIL_EVICTED || rsp_status == ST_KEY_REJECTED), rsp_is_full)

endmodule

bind sorted_insert_queue siq_checker u_siq_checker (.*);

### tb/sv/sorted_insert_queue_checker.sv
// Checker for the sorted insert queue: mirrors the held entries and compares each result beat.
module sorted_insert_queue_checker #(
   parameter int unsigned CAPACITY = siq_pkg::CAPACITY_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_ready,
   input  logic             req_cmd,
   input  siq_pkg::key_type req_key,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  siq_pkg::key_type rsp_out_value,
   input  logic [1:0]       rsp_status,
   input  logic [7:0]       rsp_entry_count,
   input  siq_pkg::key_type rsp_head_value,
   input  siq_pkg::key_type rsp_tail_value,
   input  logic             rsp_is_empty,
   input  logic             rsp_is_full,
   output int               fail_count,
   output int               pending_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import siq_pkg::*;

   typedef struct packed {
      key_type    out_value;
      status_type status;
      logic [7:0] entry_count;
      key_type    head_value;
      key_type    tail_value;
      logic       is_empty;
      logic       is_full;
   } queue_report_type;

   // Mirror of the queue: largest entry at index 0.
   key_type          entries [CAPACITY];
   int unsigned      held = 0;
   queue_report_type awaited_reports [$];

   initial fail_count = 0;

   // Apply one command to the mirror and return the report it should produce.
   function automatic queue_report_type apply_command(cmd_type cmd, key_type key);
      queue_report_type rep;
      int unsigned      pos;
      int unsigned      last;
      rep = '0;
      if (cmd == CMD_POP) begin
         if (held == 0) begin
            rep.status = ST_EMPTY_POP;
         end else begin
            rep.out_value = entries[0];
            for (int unsigned i = 1; i < held; i++) entries[i-1] = entries[i];
            held--;
         end
      end else begin
         pos = 0;
         // Skip every entry strictly greater, so the key goes ahead of equals.
         while (pos < held && key < entries[pos]) pos++;
         if (held < CAPACITY) begin
            last = held;
            held++;
         end else if (pos >= CAPACITY) begin
            rep.status    = ST_KEY_REJECTED;
            rep.out_value = key;
            last          = CAPACITY;
         end else begin
            rep.status    = ST_TAIL_EVICTED;
            rep.out_value = entries[CAPACITY-1];
            last          = CAPACITY - 1;
         end
         if (pos < CAPACITY) begin
            for (int unsigned i = last; i > pos; i--) entries[i] = entries[i-1];
            entries[pos] = key;
         end
      end
      rep.entry_count = held[7:0];
      if (held != 0) begin
         rep.head_value = entries[0];
         rep.tail_value = entries[held-1];
      end
      rep.is_empty = (held == 0);
      rep.is_full  = (held == CAPACITY);
      return rep;
   endfunction

   function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, actual %0h", name, want, got);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin
      queue_report_type want;
      if (reset) begin
         held = 0;
         awaited_reports.delete();
      end else begin
         if (req_valid && req_ready)
            awaited_reports.push_back(apply_command(cmd_type'(req_cmd), req_key));
         if (rsp_valid && rsp_ready) begin
            if (awaited_reports.size() == 0) begin
               $error("result beat with no request outstanding");
               fail_count++;
            end else begin
               want = awaited_reports.pop_front();
               compare_field("out_value", want.out_value, rsp_out_value);
               compare_field("status", want.status, rsp_status);
               compare_field("entry_count", want.entry_count, rsp_entry_count);
               compare_field("head_value", want.head_value, rsp_head_value);
               compare_field("tail_value", want.tail_value, rsp_tail_value);
               compare_field("is_empty", want.is_empty, rsp_is_empty);
               compare_field("is_full", want.is_full, rsp_is_full);
            end
         end
      end
      pending_count <= awaited_reports.size();
   end

endmodule

### tb/sv/sorted_insert_queue_tb.sv
// Top of the sorted insert queue testbench: clock, reset, request traffic and verdict.
module sorted_insert_queue_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import siq_pkg::*;

   localparam int unsigned CAP          = CAPACITY_DEFAULT;
   localparam int unsigned RANDOM_ITEMS = 550;
   localparam int unsigned IDLE_PCT     = 13;
   localparam int unsigned HOLD_ITEMS   = 60;
   localparam int unsigned CYCLE_LIMIT  = 100000;

   localparam key_type KEY_MIN = 32'sh8000_0000;
   localparam key_type KEY_MAX = 32'sh7fff_ffff;

   // Traffic shape of the random part: fill up, churn at full, drain.
   typedef enum logic [2:0] {
      MODE_FILL  = 3'b001,
      MODE_HOLD  = 3'b010,
      MODE_DRAIN = 3'b100
   } traffic_mode_type;

   logic       clock     = 1'b0;
   logic       reset     = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic       req_cmd   = 1'b0;
   key_type    req_key   = '0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   key_type    rsp_out_value;
   logic [1:0] rsp_status;
   logic [7:0] rsp_entry_count;
   key_type    rsp_head_value;
   key_type    rsp_tail_value;
   logic       rsp_is_empty;
   logic       rsp_is_full;
   int         fail_count;
   int         pending_count;

   // High during the stretch where neither side idles.
   logic             calm = 1'b0;
   int unsigned      occupancy = 0;
   int unsigned      cycle_count = 0;
   traffic_mode_type mode = MODE_FILL;
   int unsigned      hold_left = 0;
   int unsigned      pop_pct;

   sorted_insert_queue #(.CAPACITY(CAP)) dut (.*);

   sorted_insert_queue_checker #(.CAPACITY(CAP)) checker_inst (.*);

   initial begin
      forever #6 clock = ~clock;
   end

   // Stall the result side at random, except in the calm stretch.
   always @(posedge clock) begin
      rsp_ready <= !reset && (calm || $urandom_range(99) >= IDLE_PCT);
   end

   // Abort a run that hangs.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("sorted_insert_queue_tb NOT OK");
         $finish;
      end
   end

   // Present one request beat, with a random gap ahead of it, and hold it
   // until the queue takes it. Track only the fill level to steer traffic.
   task automatic send_item(cmd_type cmd, key_type key);
      while (!calm && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cmd   <= cmd;
      req_key   <= key;
      do @(posedge clock); while (!req_ready);
      if (cmd == CMD_POP) begin
         if (occupancy > 0) occupancy--;
      end else if (occupancy < CAP) begin
         occupancy++;
      end
   endtask

   // Mix of keys: clusters of small values to force ties, the extremes,
   // and full-range values. Low-biased keys sit at or just above the minimum so
   // that a full queue either rejects them or evicts a minimum tail.
   function automatic key_type pick_key(bit low_bias);
      int unsigned roll;
      roll = $urandom_range(99);
      if (low_bias && roll < 30) return KEY_MIN + key_type'($urandom_range(3));
      if (roll < 55) return key_type'(int'($urandom_range(32)) - 16);
      if (roll < 62) begin
         case ($urandom_range(3))
            0: return KEY_MIN;
            1: return KEY_MAX;
            2: return KEY_MIN + 1;
            default: return KEY_MAX - 1;
         endcase
      end
      return key_type'($urandom);
   endfunction

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed: pop on empty, extremes, ties at head and tail, drain past empty.
      send_item(CMD_POP, KEY_MAX);
      send_item(CMD_INSERT, 0);
      send_item(CMD_INSERT, KEY_MAX);
      send_item(CMD_INSERT, KEY_MIN);
      send_item(CMD_INSERT, -1);
      send_item(CMD_INSERT, 0);
      send_item(CMD_INSERT, KEY_MIN);
      send_item(CMD_INSERT, KEY_MAX);
      send_item(CMD_INSERT, 1);
      repeat (8) send_item(CMD_POP, key_type'($urandom));
      send_item(CMD_POP, KEY_MIN);
      send_item(CMD_POP, KEY_MAX);

      // Random: fill to capacity, churn while full (evictions and rejections),
      // then drain to empty; repeat as the item budget allows.
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         calm <= (n >= 250 && n < 370);
         if (mode == MODE_FILL && occupancy == CAP) begin
            mode      = MODE_HOLD;
            hold_left = HOLD_ITEMS;
         end else if (mode == MODE_HOLD && hold_left == 0) begin
            mode = MODE_DRAIN;
         end else if (mode == MODE_DRAIN && occupancy == 0) begin
            mode = MODE_FILL;
         end
         pop_pct = (mode == MODE_DRAIN) ? 88 : (mode == MODE_HOLD) ? 25 : 12;
         if ($urandom_range(99) < pop_pct) send_item(CMD_POP, key_type'($urandom));
         else send_item(CMD_INSERT, pick_key(mode == MODE_HOLD));
         if (mode == MODE_HOLD && hold_left > 0) hold_left--;
      end
      req_valid <= 1'b0;
      calm      <= 1'b0;

      // Drain outstanding results, then let the bench idle before the verdict.
      do @(posedge clock); while (pending_count != 0);
      repeat (4) @(posedge clock);
      if (fail_count == 0) begin
         $display("sorted_insert_queue_tb OK");
      end else begin
         $display("sorted_insert_queue_tb NOT OK");
      end
      $finish;
   end

endmodule
